### hdl/vsci_pkg.sv
package vsci_pkg;

	// Default geometry and code width of the screen store.
	localparam int COLUMNS_DEF   = 40;
	localparam int ROWS_DEF      = 23;
	localparam int TOP_ROW_DEF   = 1;
	localparam int CODE_BITS_DEF = 16;

	// Control codes of the stream.
	localparam logic [15:0] CODE_LEFT      = 16'h0008;
	localparam logic [15:0] CODE_RIGHT     = 16'h0009;
	localparam logic [15:0] CODE_DOWN      = 16'h000a;
	localparam logic [15:0] CODE_UP        = 16'h000b;
	localparam logic [15:0] CODE_CLS       = 16'h000c;
	localparam logic [15:0] CODE_CR        = 16'h000d;
	localparam logic [15:0] CODE_REPEAT    = 16'h0012;
	localparam logic [15:0] CODE_CLR_ROW   = 16'h0018;
	localparam logic [15:0] CODE_ESC       = 16'h001b;
	localparam logic [15:0] CODE_HOME      = 16'h001e;
	localparam logic [15:0] CODE_ADDRESS   = 16'h001f;

	// Parameter bytes.
	localparam logic [7:0] ESC_FOLLOW  = 8'h22;
	localparam logic [7:0] ADDR_OFFSET = 8'h41;
	localparam logic [7:0] REPEAT_MOD  = 8'h1f;

	localparam int SPACE_CODE = 32;

	// Run status codes.
	localparam logic [1:0] STAT_RUN    = 2'd0;
	localparam logic [1:0] STAT_FINISH = 2'd1;
	localparam logic [1:0] STAT_HALT   = 2'd2;

	// Repeat count: a byte modulo 31. Since 32 is 1 modulo 31, the top three
	// bits fold onto the low five, and one compare and subtract finishes it.
	function automatic logic [4:0] repeat_count(input logic [7:0] b);
		logic [5:0] s;
		s = 6'(b[7:5]) + 6'(b[4:0]);
		if (s >= 6'(REPEAT_MOD)) begin
			s = s - 6'(REPEAT_MOD);
		end
		return s[4:0];
	endfunction

endpackage

### hdl/videotex_screen_code_interpreter.sv
// Videotex screen code interpreter. Each input item either feeds one code of a
// videotex stream (mode 0) or reads back one cell of the ROWS x COLUMNS screen
// store (mode 1), and each item gives exactly one result: the run status, the
// cell read (0 for a stream code or an address beyond the store) and the cursor.
// The screen lives in one synchronous memory with a single write port and a
// registered read port. For an ordinary code, a cursor control or a read, the
// item is decoded and written at acceptance, and the result register is loaded
// once the output is free. Clear screen walks the whole store, one cell per
// cycle, clear to end of row walks up to COLUMNS cells, and repeat writes one
// cell per cycle for its count (0 to 30); the single write port of the memory
// sets that pace, and no item is taken meanwhile. After reset the store is
// filled with spaces by a pass over all ROWS*COLUMNS cells, during which
// in_ready stays low. A new item may be accepted while the previous result
// still waits on the output.
module videotex_screen_code_interpreter
	import vsci_pkg::*;
#(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int TOP_ROW   = TOP_ROW_DEF,
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] code,
	input  logic [9:0]  read_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] cell_code,
	output logic        cursor_valid,
	output logic [9:0]  cursor_position
);

	localparam int SCREEN_SIZE = COLUMNS * ROWS;
	localparam int IDX_W       = $clog2(SCREEN_SIZE);
	localparam int CNT_W       = IDX_W + 1;
	localparam int COL_W       = $clog2(COLUMNS);

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FILL   = 5'b00010,
		ST_REPEAT = 5'b00100,
		ST_DONE   = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	// Parse phase of the code stream.
	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_REPEAT = 6'b000010,
		PH_ESC1   = 6'b000100,
		PH_ESC2   = 6'b001000,
		PH_ROW    = 6'b010000,
		PH_COL    = 6'b100000
	} phase_t;

	state_t st_q;
	phase_t ph_q;

	logic [CODE_BITS-1:0] screen_mem [SCREEN_SIZE];
	logic [CODE_BITS-1:0] rd_q;

	logic [IDX_W-1:0]     cursor_q;
	logic [COL_W-1:0]     col_q;
	logic                 cursor_on_q;
	logic [CODE_BITS-1:0] last_plain_q;
	logic [1:0]           run_q;
	logic                 row_ok_q;
	logic [IDX_W-1:0]     row_base_q;
	logic [4:0]           rep_cnt_q;
	logic [IDX_W-1:0]     fill_ptr_q;
	logic [CNT_W-1:0]     fill_end_q;
	logic                 fill_item_q;
	logic                 item_read_q;
	logic                 read_ok_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [15:0]          cell_code_q;
	logic                 cursor_valid_q;
	logic [9:0]           cursor_position_q;

	logic                 accept;
	logic                 stream_go;
	logic                 plain;
	logic                 out_free;
	logic                 fill_last;
	logic [7:0]           pbyte;
	logic [7:0]           row_rel;
	logic [7:0]           col_rel;
	logic [15:0]          row_base;

	logic [IDX_W-1:0]     cur_inc;
	logic [COL_W-1:0]     col_inc;
	logic [IDX_W-1:0]     cur_dec;
	logic [COL_W-1:0]     col_dec;
	logic [CNT_W-1:0]     down_sum;
	logic [IDX_W-1:0]     cur_down;
	logic [IDX_W-1:0]     cur_up;
	logic [IDX_W-1:0]     row_start;
	logic [CNT_W-1:0]     row_end;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [CODE_BITS-1:0] wr_data;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign stream_go = accept && !mode && (run_q == STAT_RUN);
	assign out_free  = !out_valid_q || out_ready;
	assign pbyte     = code[7:0];
	assign row_rel   = pbyte - ADDR_OFFSET;
	assign col_rel   = pbyte - ADDR_OFFSET;
	// Only meaningful when the row lies on screen, which keeps it narrow.
	assign row_base  = 16'(row_rel - 8'(TOP_ROW)) * 16'(COLUMNS);
	assign fill_last = ((CNT_W'(fill_ptr_q) + 1'b1) == fill_end_q);

	// Codes outside the control set are plain, written at an enabled cursor.
	always_comb begin
		unique case (code) inside
			16'h0008, 16'h0009, 16'h000a, 16'h000b, 16'h000c, 16'h000d,
			16'h000e, 16'h000f, 16'h0011, 16'h0012, 16'h0013, 16'h0014,
			16'h0015, 16'h0016, 16'h0017, 16'h0018, 16'h0019, 16'h001a,
			16'h001b, 16'h001c, 16'h001d, 16'h001e, 16'h001f: plain = 1'b0;
			default: plain = 1'b1;
		endcase
	end

	// Cursor neighbors, with wrap over the whole screen. The column is kept
	// alongside the cell index so that row start and row end need no divide.
	always_comb begin
		cur_inc   = (CNT_W'(cursor_q) == CNT_W'(SCREEN_SIZE - 1)) ? '0 : cursor_q + 1'b1;
		col_inc   = (CNT_W'(col_q) == CNT_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
		cur_dec   = (cursor_q == '0) ? IDX_W'(SCREEN_SIZE - 1) : cursor_q - 1'b1;
		col_dec   = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
		down_sum  = CNT_W'(cursor_q) + CNT_W'(COLUMNS);
		cur_down  = (down_sum >= CNT_W'(SCREEN_SIZE)) ?
			IDX_W'(down_sum - CNT_W'(SCREEN_SIZE)) : IDX_W'(down_sum);
		cur_up    = (CNT_W'(cursor_q) >= CNT_W'(COLUMNS)) ?
			IDX_W'(CNT_W'(cursor_q) - CNT_W'(COLUMNS)) :
			IDX_W'(CNT_W'(cursor_q) + CNT_W'(SCREEN_SIZE - COLUMNS));
		row_start = cursor_q - IDX_W'(col_q);
		row_end   = CNT_W'(cursor_q) - CNT_W'(col_q) + CNT_W'(COLUMNS);
	end

	// Single write port: fills, repeat writes and plain codes never overlap.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cursor_q;
		wr_data = last_plain_q;
		if (st_q == ST_FILL) begin
			wr_en   = 1'b1;
			wr_addr = fill_ptr_q;
			wr_data = CODE_BITS'(SPACE_CODE);
		end else if (st_q == ST_REPEAT) begin
			wr_en = (rep_cnt_q != '0) && cursor_on_q;
		end else if (stream_go && (ph_q == PH_IDLE) && plain) begin
			wr_en   = cursor_on_q;
			wr_data = CODE_BITS'(code);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			screen_mem[wr_addr] <= wr_data;
		end
		if (accept && mode) begin
			rd_q <= screen_mem[IDX_W'(read_address)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_FILL;
			ph_q         <= PH_IDLE;
			cursor_q     <= '0;
			col_q        <= '0;
			cursor_on_q  <= 1'b1;
			last_plain_q <= '0;
			run_q        <= STAT_RUN;
			row_ok_q     <= 1'b0;
			row_base_q   <= '0;
			rep_cnt_q    <= '0;
			fill_ptr_q   <= '0;
			fill_end_q   <= CNT_W'(SCREEN_SIZE);
			fill_item_q  <= 1'b0;
			item_read_q  <= 1'b0;
			read_ok_q    <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q        <= ST_DONE;
						fill_item_q <= 1'b1;
						item_read_q <= mode;
						read_ok_q   <= (32'(read_address) < 32'(SCREEN_SIZE));
					end
					if (stream_go) begin
						ph_q <= PH_IDLE;
						unique case (ph_q)
							PH_REPEAT: begin
								rep_cnt_q <= repeat_count(pbyte);
								st_q      <= ST_REPEAT;
							end
							PH_ESC1: begin
								if (pbyte == ESC_FOLLOW) begin
									ph_q <= PH_ESC2;
								end
							end
							PH_ESC2: begin
								if (pbyte == ADDR_OFFSET) begin
									run_q <= STAT_HALT;
								end
							end
							PH_ROW: begin
								if (pbyte < ADDR_OFFSET) begin
									run_q <= STAT_HALT;
								end else begin
									row_ok_q   <= (row_rel >= 8'(TOP_ROW)) &&
										(row_rel < 8'(TOP_ROW + ROWS));
									row_base_q <= IDX_W'(row_base);
									ph_q       <= PH_COL;
								end
							end
							PH_COL: begin
								if (pbyte < ADDR_OFFSET) begin
									run_q <= STAT_FINISH;
								end else if (row_ok_q && (col_rel < 8'(COLUMNS))) begin
									cursor_q    <= row_base_q + IDX_W'(col_rel);
									col_q       <= COL_W'(col_rel);
									cursor_on_q <= 1'b1;
								end else begin
									cursor_on_q <= 1'b0;
								end
							end
							PH_IDLE: begin
								unique case (code)
									CODE_LEFT: begin
										if (cursor_on_q) begin
											cursor_q <= cur_dec;
											col_q    <= col_dec;
										end
									end
									CODE_RIGHT: begin
										if (cursor_on_q) begin
											cursor_q <= cur_inc;
											col_q    <= col_inc;
										end
									end
									CODE_DOWN: begin
										if (cursor_on_q) begin
											cursor_q <= cur_down;
										end
									end
									CODE_UP: begin
										if (cursor_on_q) begin
											cursor_q <= cur_up;
										end
									end
									CODE_CLS: begin
										fill_ptr_q <= '0;
										fill_end_q <= CNT_W'(SCREEN_SIZE);
										st_q       <= ST_FILL;
									end
									CODE_CR: begin
										if (cursor_on_q) begin
											cursor_q <= row_start;
											col_q    <= '0;
										end
									end
									CODE_REPEAT: ph_q <= PH_REPEAT;
									CODE_CLR_ROW: begin
										if (cursor_on_q) begin
											fill_ptr_q <= cursor_q;
											fill_end_q <= row_end;
											st_q       <= ST_FILL;
										end
									end
									CODE_ESC: ph_q <= PH_ESC1;
									CODE_HOME: begin
										cursor_q    <= '0;
										col_q       <= '0;
										cursor_on_q <= 1'b1;
									end
									CODE_ADDRESS: ph_q <= PH_ROW;
									default: begin
										if (plain) begin
											last_plain_q <= CODE_BITS'(code);
											if (cursor_on_q) begin
												cursor_q <= cur_inc;
												col_q    <= col_inc;
											end
										end
									end
								endcase
							end
							default: ph_q <= PH_IDLE;
						endcase
					end
				end
				ST_FILL: begin
					fill_ptr_q <= fill_ptr_q + 1'b1;
					if (fill_last) begin
						st_q <= fill_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_REPEAT: begin
					if ((rep_cnt_q == '0) || !cursor_on_q) begin
						st_q <= ST_DONE;
					end else begin
						rep_cnt_q <= rep_cnt_q - 1'b1;
						cursor_q  <= cur_inc;
						col_q     <= col_inc;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: loaded when the item's work is done and the output is
	// free, so the next item can already be taken while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			status_q          <= STAT_RUN;
			cell_code_q       <= '0;
			cursor_valid_q    <= 1'b0;
			cursor_position_q <= '0;
		end else if (((st_q == ST_DONE) || (st_q == ST_HOLD)) && out_free) begin
			out_valid_q       <= 1'b1;
			status_q          <= run_q;
			cell_code_q       <= (item_read_q && read_ok_q) ? 16'(rd_q) : 16'd0;
			cursor_valid_q    <= cursor_on_q;
			cursor_position_q <= cursor_on_q ? 10'(cursor_q) : 10'd0;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign cell_code       = cell_code_q;
	assign cursor_valid    = cursor_valid_q;
	assign cursor_position = cursor_position_q;

endmodule

### verif/videotex_screen_code_interpreter_tb.sv
module videotex_screen_code_interpreter_tb;
	import vsci_pkg::*;

	// Geometry of the screen store under test, taken from the package defaults.
	localparam int unsigned SCREEN_CELLS = COLUMNS_DEF * ROWS_DEF;

	// A run with no accepted item on either side for this many cycles is hung.
	// The longest legal quiet stretch is the clearing pass after reset or a clear
	// screen plus a sender gap and a receiver stall, or the long receiver
	// hold-off, so this leaves a wide margin.
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD_CYCLES = 300;

	// The byte that completes the incompatible escape ESC 0x22 0x41.
	localparam logic [7:0] ESC_INCOMPATIBLE = 8'h41;
	// The one code inside the control range that is still written as plain.
	localparam logic [15:0] CODE_GAP_PLAIN = 16'h0010;
	// Control codes that the interpreter accepts and then ignores.
	localparam int IGNORED_COUNT = 12;
	localparam logic [15:0] IGNORED_CODES [IGNORED_COUNT] = '{
		16'h000e, 16'h000f, 16'h0011, 16'h0013, 16'h0014, 16'h0015,
		16'h0016, 16'h0017, 16'h0019, 16'h001a, 16'h001c, 16'h001d
	};

	// Where the stream parser stands between codes.
	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_REPEAT_COUNT,
		PARSE_ESC_FIRST,
		PARSE_ESC_SECOND,
		PARSE_ADDR_ROW,
		PARSE_ADDR_COL
	} parse_step_t;

	// One result item as the block reports it.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] cell_data;
		logic        cursor_on;
		logic [9:0]  cursor_at;
	} screen_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [15:0] code = '0;
	logic [9:0]  read_address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] cell_code;
	logic        cursor_valid;
	logic [9:0]  cursor_position;

	// Our own copy of the screen and the interpreter state.
	logic [15:0]  shadow_screen [SCREEN_CELLS];
	int unsigned  cursor_idx = 0;
	logic         cursor_on = 1'b1;
	logic [15:0]  last_plain = '0;
	parse_step_t  parse_at = PARSE_IDLE;
	logic [7:0]   row_byte = '0;
	logic [1:0]   run_state = STAT_RUN;

	// Results still owed by the block, oldest first.
	screen_result_t results_due [$];

	int  error_count = 0;
	int  idle_cycles = 0;
	int  tx_gap_pct = 0;
	int  rx_stall_pct = 0;
	// When set, neither side idles: used for the final part of the run.
	bit  quiet = 1'b0;
	// Asks the receiver for one long hold-off.
	bit  long_hold_req = 1'b0;

	videotex_screen_code_interpreter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.code           (code),
		.read_address   (read_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.cell_code      (cell_code),
		.cursor_valid   (cursor_valid),
		.cursor_position(cursor_position)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Screen predictor.
	// ------------------------------------------------------------------

	// Cursor moves do nothing while the cursor is inhibited.
	function automatic void move_cursor(input int unsigned delta);
		if (cursor_on) begin
			cursor_idx = (cursor_idx + delta) % SCREEN_CELLS;
		end
	endfunction

	// Writes one cell at the cursor and advances, unless inhibited.
	function automatic void write_at_cursor(input logic [15:0] c);
		if (cursor_on) begin
			shadow_screen[cursor_idx] = c;
			move_cursor(1);
		end
	endfunction

	function automatic void blank_cells(input int unsigned from, input int unsigned upto);
		for (int unsigned n = from; n < upto && n < SCREEN_CELLS; n++) begin
			shadow_screen[n] = SPACE_CODE;
		end
	endfunction

	function automatic bit is_ignored_code(input logic [15:0] c);
		bit hit;
		hit = 1'b0;
		for (int k = 0; k < IGNORED_COUNT; k++) begin
			if (c == IGNORED_CODES[k]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// A code that is not written to the screen when it arrives in the idle step.
	function automatic bit is_control_code(input logic [15:0] c);
		return c >= CODE_LEFT && c <= CODE_ADDRESS && c != CODE_GAP_PLAIN;
	endfunction

	// A code that arrives while the parser expects a control or a plain code.
	function automatic void apply_idle_code(input logic [15:0] c);
		if (is_ignored_code(c)) begin
			return;
		end
		case (c)
			CODE_LEFT:    move_cursor(SCREEN_CELLS - 1);
			CODE_RIGHT:   move_cursor(1);
			CODE_DOWN:    move_cursor(COLUMNS_DEF % SCREEN_CELLS);
			CODE_UP:      move_cursor(SCREEN_CELLS - (COLUMNS_DEF % SCREEN_CELLS));
			CODE_CLS:     blank_cells(0, SCREEN_CELLS);
			CODE_CR: begin
				if (cursor_on) begin
					cursor_idx = (cursor_idx / COLUMNS_DEF) * COLUMNS_DEF;
				end
			end
			CODE_REPEAT:  parse_at = PARSE_REPEAT_COUNT;
			CODE_CLR_ROW: begin
				if (cursor_on) begin
					blank_cells(cursor_idx, (cursor_idx / COLUMNS_DEF + 1) * COLUMNS_DEF);
				end
			end
			CODE_ESC:     parse_at = PARSE_ESC_FIRST;
			CODE_HOME: begin
				cursor_idx = 0;
				cursor_on = 1'b1;
			end
			CODE_ADDRESS: parse_at = PARSE_ADDR_ROW;
			default: begin
				// A plain code is remembered for repeat even when it cannot be written.
				write_at_cursor(c);
				last_plain = c;
			end
		endcase
	endfunction

	function automatic void apply_stream_code(input logic [15:0] c);
		logic [7:0]  b;
		parse_step_t was;
		int unsigned row;
		int unsigned col;
		b = c[7:0];
		was = parse_at;
		parse_at = PARSE_IDLE;
		case (was)
			PARSE_REPEAT_COUNT: begin
				for (int n = 0; n < b % REPEAT_MOD; n++) begin
					write_at_cursor(last_plain);
				end
			end
			PARSE_ESC_FIRST: begin
				if (b == ESC_FOLLOW) begin
					parse_at = PARSE_ESC_SECOND;
				end
			end
			PARSE_ESC_SECOND: begin
				if (b == ESC_INCOMPATIBLE) begin
					run_state = STAT_HALT;
				end
			end
			PARSE_ADDR_ROW: begin
				if (b < ADDR_OFFSET) begin
					run_state = STAT_HALT;
				end else begin
					row_byte = b;
					parse_at = PARSE_ADDR_COL;
				end
			end
			PARSE_ADDR_COL: begin
				if (b < ADDR_OFFSET) begin
					run_state = STAT_FINISH;
				end else begin
					row = row_byte - ADDR_OFFSET;
					col = b - ADDR_OFFSET;
					if (row >= TOP_ROW_DEF && row < TOP_ROW_DEF + ROWS_DEF &&
						col < COLUMNS_DEF) begin
						cursor_idx = (row - TOP_ROW_DEF) * COLUMNS_DEF + col;
						cursor_on = 1'b1;
					end else begin
						// An address off the screen inhibits the cursor.
						cursor_on = 1'b0;
					end
				end
			end
			default: apply_idle_code(c);
		endcase
	endfunction

	// Updates the shadow state for one accepted item and gives its result.
	function automatic screen_result_t interpret_item(input logic is_read,
		input logic [15:0] c, input logic [9:0] a);
		screen_result_t r;
		r.cell_data = '0;
		if (is_read) begin
			if (a < SCREEN_CELLS) begin
				r.cell_data = shadow_screen[a];
			end
		end else if (run_state == STAT_RUN) begin
			// Once finished or halted, stream codes have no effect.
			apply_stream_code(c);
		end
		r.status = run_state;
		r.cursor_on = cursor_on;
		r.cursor_at = cursor_on ? 10'(cursor_idx) : '0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------

	// Offers one item, waits for it to be taken and books its result.
	// Valid is left high on return so that back-to-back items never see it
	// lowered and raised in the same step; a gap or the end lowers it.
	task automatic send_item(input logic is_read, input logic [15:0] c,
		input logic [9:0] a);
		if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= is_read;
		code <= c;
		read_address <= a;
		do @(posedge clk); while (!in_ready);
		results_due.push_back(interpret_item(is_read, c, a));
	endtask

	task automatic feed_code(input logic [15:0] c);
		send_item(1'b0, c, 10'($urandom));
	endtask

	task automatic read_cell(input int unsigned a);
		send_item(1'b1, 16'($urandom), 10'(a));
	endtask

	// A parameter byte carried in the low half of a code with random upper bits.
	function automatic logic [15:0] with_byte(input logic [7:0] b);
		logic [15:0] w;
		w = 16'($urandom);
		w[7:0] = b;
		return w;
	endfunction

	function automatic logic [15:0] random_plain();
		logic [15:0] c;
		c = 16'($urandom);
		case ($urandom_range(0, 3))
			0:       c[15:8] = '0;
			1:       c[15:5] = '0;
			default: ;
		endcase
		// Shift any control code into the plain range above it.
		if (is_control_code(c)) begin
			c[5] = 1'b1;
		end
		return c;
	endfunction

	function automatic logic [7:0] onscreen_row_byte();
		return 8'(ADDR_OFFSET + $urandom_range(TOP_ROW_DEF, TOP_ROW_DEF + ROWS_DEF - 1));
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 12;
			default: return 40;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver side, result checking and the watchdog.
	// ------------------------------------------------------------------

	// Ready drops in random bursts, or once for a long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && arst_n && $urandom_range(0, 99) < rx_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		screen_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result item", 1, 0);
			end else begin
				want = results_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (cell_code !== want.cell_data)
					report_mismatch("cell_code", cell_code, want.cell_data);
				if (cursor_valid !== want.cursor_on)
					report_mismatch("cursor_valid", cursor_valid, want.cursor_on);
				if (cursor_position !== want.cursor_at)
					report_mismatch("cursor_position", cursor_position, want.cursor_at);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Extreme plain codes, including the plain code hidden in the control range.
	task automatic test_plain_codes();
		feed_code(16'hffff);
		feed_code(16'h0000);
		feed_code(CODE_GAP_PLAIN);
		read_cell(0);
		read_cell(1);
	endtask

	// Every move, wrapping across both ends of the store.
	task automatic test_cursor_moves();
		feed_code(CODE_HOME);
		feed_code(CODE_LEFT);
		feed_code(16'h007f);
		feed_code(CODE_UP);
		feed_code(CODE_DOWN);
		feed_code(CODE_RIGHT);
		feed_code(CODE_CR);
		read_cell(SCREEN_CELLS - 1);
	endtask

	// Repeat counts of the widest byte and of the largest remainder, then clears.
	task automatic test_repeat_and_clear();
		feed_code(CODE_REPEAT);
		feed_code(with_byte(8'hff));
		feed_code(CODE_REPEAT);
		feed_code(with_byte(8'(REPEAT_MOD - 1)));
		feed_code(CODE_CLR_ROW);
		feed_code(CODE_CLS);
		read_cell(6);
	endtask

	// The last cell by address, then an inhibited cursor and its release.
	task automatic test_addressing();
		feed_code(CODE_ADDRESS);
		feed_code(with_byte(8'(ADDR_OFFSET + TOP_ROW_DEF + ROWS_DEF - 1)));
		feed_code(with_byte(8'(ADDR_OFFSET + COLUMNS_DEF - 1)));
		feed_code(CODE_ADDRESS);
		feed_code(with_byte(ADDR_OFFSET));
		feed_code(with_byte(ADDR_OFFSET));
		feed_code(16'h1234);
		feed_code(CODE_RIGHT);
		feed_code(CODE_HOME);
	endtask

	// The receiver holds off for a long time while items keep coming, so the
	// block backs up and drops in_ready until the results drain.
	task automatic test_output_backpressure();
		tx_gap_pct = 0;
		long_hold_req = 1'b1;
		repeat (6) begin
			feed_code(random_plain());
			read_cell((cursor_idx + SCREEN_CELLS - 1) % SCREEN_CELLS);
		end
	endtask

	// One well-formed sequence that never ends the stream.
	task automatic send_random_sequence();
		int unsigned pick;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			feed_code(random_plain());
		end else if (pick < 52) begin
			case ($urandom_range(0, 5))
				0:       feed_code(CODE_LEFT);
				1:       feed_code(CODE_RIGHT);
				2:       feed_code(CODE_DOWN);
				3:       feed_code(CODE_UP);
				4:       feed_code(CODE_CR);
				default: feed_code(CODE_HOME);
			endcase
		end else if (pick < 55) begin
			feed_code(CODE_CLR_ROW);
		end else if (pick < 56) begin
			feed_code(CODE_CLS);
		end else if (pick < 63) begin
			feed_code(CODE_REPEAT);
			feed_code(16'($urandom));
		end else if (pick < 71) begin
			// Mostly on screen; now and then a row or column that inhibits.
			feed_code(CODE_ADDRESS);
			if ($urandom_range(0, 5) == 0) begin
				b = ($urandom_range(0, 1) == 0) ? ADDR_OFFSET :
					8'($urandom_range(ADDR_OFFSET + TOP_ROW_DEF + ROWS_DEF, 255));
			end else begin
				b = onscreen_row_byte();
			end
			feed_code(with_byte(b));
			if ($urandom_range(0, 5) == 0) begin
				b = 8'($urandom_range(ADDR_OFFSET + COLUMNS_DEF, 255));
			end else begin
				b = 8'(ADDR_OFFSET + $urandom_range(0, COLUMNS_DEF - 1));
			end
			feed_code(with_byte(b));
		end else if (pick < 74) begin
			// Escapes that are consumed without halting.
			feed_code(CODE_ESC);
			if ($urandom_range(0, 1) == 0) begin
				b = 8'($urandom);
				if (b == ESC_FOLLOW) begin
					b = b + 8'd1;
				end
				feed_code(with_byte(b));
			end else begin
				feed_code(with_byte(ESC_FOLLOW));
				b = 8'($urandom);
				if (b == ESC_INCOMPATIBLE) begin
					b = b - 8'd1;
				end
				feed_code(with_byte(b));
			end
		end else if (pick < 78) begin
			feed_code(IGNORED_CODES[$urandom_range(0, IGNORED_COUNT - 1)]);
		end else if (pick < 89) begin
			// Look just behind the cursor, where the latest writes landed.
			read_cell((cursor_idx + SCREEN_CELLS - $urandom_range(0, 3)) % SCREEN_CELLS);
		end else begin
			read_cell($urandom_range(0, 1023));
		end
	endtask

	// Random sequences in segments, each with its own amount of idling.
	task automatic test_random_stream();
		for (int seg = 0; seg < 8; seg++) begin
			tx_gap_pct = pick_idle_pct();
			rx_stall_pct = pick_idle_pct();
			repeat (40) send_random_sequence();
		end
	endtask

	// Ends the stream in one of its three ways, then shows that stream codes
	// are ignored while reads still work. No idling from here on.
	task automatic test_stream_end();
		quiet = 1'b1;
		case ($urandom_range(0, 2))
			0: begin
				feed_code(CODE_ESC);
				feed_code(with_byte(ESC_FOLLOW));
				feed_code(with_byte(ESC_INCOMPATIBLE));
			end
			1: begin
				feed_code(CODE_ADDRESS);
				feed_code(with_byte(8'($urandom_range(0, ADDR_OFFSET - 1))));
			end
			default: begin
				feed_code(CODE_ADDRESS);
				feed_code(with_byte(onscreen_row_byte()));
				feed_code(with_byte(8'($urandom_range(0, ADDR_OFFSET - 1))));
			end
		endcase
		feed_code(random_plain());
		feed_code(CODE_HOME);
		feed_code(CODE_CLS);
		read_cell($urandom_range(0, SCREEN_CELLS - 1));
		read_cell((cursor_idx + SCREEN_CELLS - 1) % SCREEN_CELLS);
	endtask

	initial begin
		for (int n = 0; n < SCREEN_CELLS; n++) begin
			shadow_screen[n] = SPACE_CODE;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_plain_codes();
		test_cursor_moves();
		test_repeat_and_clear();
		test_addressing();
		test_output_backpressure();
		test_random_stream();
		test_stream_end();

		in_valid <= 1'b0;
		// The watchdog catches results that never come.
		while (results_due.size() != 0) @(posedge clk);
		// Give any stray result time to show up before the verdict.
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
